// ----- src/meter_frame_deframer_unit_assert.svh -----
// Assertion macros for the meter frame deframer.
`ifndef METER_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`define METER_FRAME_DEFRAMER_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
`define MFD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer check failed");
`define MFD_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer check failed");
`else
`define MFD_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define MFD_ASSERT_NXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ----- src/mfd_pkg.sv -----
`timescale 1ns / 1ps
package mfd_pkg;

   localparam int unsigned QDepth    = 4;
   localparam int unsigned QAw       = $clog2(QDepth);
   localparam int unsigned QCw       = $clog2(QDepth + 1);
   localparam int unsigned AddrBytes = 6;

   localparam logic KIND_DATA  = 1'b0;
   localparam logic KIND_FRAME = 1'b1;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_NO_HDR2 = 2'd1;
   localparam logic [1:0] ST_BAD_SUM = 2'd2;
   localparam logic [1:0] ST_BAD_END = 2'd3;

   localparam logic [1:0] REG_HEADER   = 2'd0;
   localparam logic [1:0] REG_END      = 2'd1;
   localparam logic [1:0] REG_PREAMBLE = 2'd2;
   localparam logic [1:0] REG_OFFSET   = 2'd3;

   localparam logic [7:0] HEADER_RST   = 8'h68;
   localparam logic [7:0] END_RST      = 8'h16;
   localparam logic [7:0] PREAMBLE_RST = 8'hFE;
   localparam logic [7:0] OFFSET_RST   = 8'h33;

   typedef struct packed {
      logic [7:0] header_byte;
      logic [7:0] end_byte;
      logic [7:0] preamble_byte;
      logic [7:0] data_offset;
   } cfg_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  data_value;
      logic [7:0]  data_index;
      logic [47:0] frame_addr;
      logic [7:0]  frame_ctl;
      logic [7:0]  data_len;
      logic        preamble_seen;
      logic [1:0]  frame_status;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type res;
   } push_type;

endpackage

// ----- src/mfd_ifs.sv -----
`timescale 1ns / 1ps
interface mfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface mfd_rsp_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [7:0]  data_value;
   logic [7:0]  data_index;
   logic [47:0] frame_addr;
   logic [7:0]  frame_ctl;
   logic [7:0]  data_len;
   logic        preamble_seen;
   logic [1:0]  frame_status;

   modport source (output valid, output kind, output data_value, output data_index,
                   output frame_addr, output frame_ctl, output data_len,
                   output preamble_seen, output frame_status, input ready);
   modport sink (input valid, input kind, input data_value, input data_index,
                 input frame_addr, input frame_ctl, input data_len,
                 input preamble_seen, input frame_status, output ready);
endinterface

// ----- src/meter_frame_deframer_unit.sv -----
`timescale 1ns / 1ps
// Meter frame deframer: takes one received byte per req beat, hunts for the
// header byte, then walks address, second header, control, length, data,
// checksum and end byte. Each data byte gives one rsp beat (kind 0, value
// with the offset removed, its index). The end byte, or a bad second header,
// gives one frame beat (kind 1) with address, control, length, preamble flag
// and status. Other bytes give no rsp beat.
// Registers load through csr_we / csr_index / csr_wdata; the user must load them
// only while idle, as the block itself does not enforce it. An accepted byte is
// registered in the parse stage; its result is then written into the result
// queue, whose head drives rsp. Throughput: one byte per cycle while req_if.ready
// is high; a four-entry result queue sits between the parse stage and rsp.
// When rsp stalls the queue fills and req_if.ready drops once it cannot
// take the byte in flight plus one more; nothing is lost.
// Reset (synchronous) restores the register defaults, empties the queue
// and returns the parser to header hunting.
module meter_frame_deframer_unit (
   input  logic       clock,
   input  logic       reset,
   mfd_req_if.sink    req_if,
   mfd_rsp_if.source  rsp_if,
   input  logic       csr_we,
   input  logic [1:0] csr_index,
   input  logic [7:0] csr_wdata
);

   `include "meter_frame_deframer_unit_assert.svh"

   mfd_pkg::cfg_type        cfg;
   mfd_pkg::push_type       push;
   mfd_pkg::result_type     head;
   logic                    head_valid;
   logic                    stage_valid;
   logic                    take;
   logic [mfd_pkg::QCw-1:0] fill;
   logic [mfd_pkg::QCw-1:0] load;

   assign load          = fill + mfd_pkg::QCw'(stage_valid);
   assign req_if.ready  = (load < mfd_pkg::QCw'(mfd_pkg::QDepth));
   assign take          = req_if.valid && req_if.ready;

   mfd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mfd_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .take        (take),
      .rx_byte     (req_if.rx_byte),
      .stage_valid (stage_valid),
      .push        (push)
   );

   mfd_rspq u_rspq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .pop_ready  (rsp_if.ready),
      .head_valid (head_valid),
      .head       (head),
      .fill       (fill)
   );

   assign rsp_if.valid         = head_valid;
   assign rsp_if.kind          = head.kind;
   assign rsp_if.data_value    = head.data_value;
   assign rsp_if.data_index    = head.data_index;
   assign rsp_if.frame_addr    = head.frame_addr;
   assign rsp_if.frame_ctl     = head.frame_ctl;
   assign rsp_if.data_len      = head.data_len;
   assign rsp_if.preamble_seen = head.preamble_seen;
   assign rsp_if.frame_status  = head.frame_status;

   `MFD_ASSERT_IMP(a_fill_bound, clock, reset, 1'b1, fill <= mfd_pkg::QCw'(mfd_pkg::QDepth))
   `MFD_ASSERT_IMP(a_push_room, clock, reset, push.valid, fill < mfd_pkg::QCw'(mfd_pkg::QDepth))
   `MFD_ASSERT_NXT(a_stage_load, clock, reset, take, stage_valid)
   `MFD_ASSERT_IMP(a_data_ok, clock, reset, rsp_if.valid && (rsp_if.kind == mfd_pkg::KIND_DATA), rsp_if.frame_status == mfd_pkg::ST_OK)

endmodule

// ----- src/mfd_csr.sv -----
`timescale 1ns / 1ps
module mfd_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [1:0]       csr_index,
   input  logic [7:0]       csr_wdata,
   output mfd_pkg::cfg_type cfg
);

   mfd_pkg::cfg_type cfg_ff;
   mfd_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mfd_pkg::REG_HEADER:   cfg_in.header_byte   = csr_wdata;
            mfd_pkg::REG_END:      cfg_in.end_byte      = csr_wdata;
            mfd_pkg::REG_PREAMBLE: cfg_in.preamble_byte = csr_wdata;
            mfd_pkg::REG_OFFSET:   cfg_in.data_offset   = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.header_byte   <= mfd_pkg::HEADER_RST;
         cfg_ff.end_byte      <= mfd_pkg::END_RST;
         cfg_ff.preamble_byte <= mfd_pkg::PREAMBLE_RST;
         cfg_ff.data_offset   <= mfd_pkg::OFFSET_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- src/mfd_parse.sv -----
`timescale 1ns / 1ps
module mfd_parse (
   input  logic              clock,
   input  logic              reset,
   input  mfd_pkg::cfg_type  cfg,
   input  logic              take,
   input  logic [7:0]        rx_byte,
   output logic              stage_valid,
   output mfd_pkg::push_type push
);

   localparam logic [2:0] PH_HUNT = 3'd0;
   localparam logic [2:0] PH_ADDR = 3'd1;
   localparam logic [2:0] PH_HDR2 = 3'd2;
   localparam logic [2:0] PH_CTL  = 3'd3;
   localparam logic [2:0] PH_LEN  = 3'd4;
   localparam logic [2:0] PH_DATA = 3'd5;
   localparam logic [2:0] PH_CS   = 3'd6;
   localparam logic [2:0] PH_END  = 3'd7;

   logic        stv_ff, stv_in;
   logic [7:0]  byte_ff;
   logic [2:0]  phase_ff, phase_in;
   logic [7:0]  cnt_ff, cnt_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  len_ff, len_in;
   logic [47:0] addr_ff, addr_in;
   logic [7:0]  ctl_ff, ctl_in;
   logic        sok_ff, sok_in;
   logic        pre_ff, pre_in;
   logic [7:0]  cnt_nx;
   logic [7:0]  sum_nx;
   mfd_pkg::push_type push_in;

   assign stv_in = take;
   assign cnt_nx = cnt_ff + 8'd1;
   assign sum_nx = sum_ff + byte_ff;

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      sum_in   = sum_ff;
      len_in   = len_ff;
      addr_in  = addr_ff;
      ctl_in   = ctl_ff;
      sok_in   = sok_ff;
      pre_in   = pre_ff;
      push_in.valid                = 1'b0;
      push_in.res.kind             = mfd_pkg::KIND_FRAME;
      push_in.res.data_value       = 8'd0;
      push_in.res.data_index       = 8'd0;
      push_in.res.frame_addr       = addr_ff;
      push_in.res.frame_ctl        = ctl_ff;
      push_in.res.data_len         = len_ff;
      push_in.res.preamble_seen    = pre_ff;
      push_in.res.frame_status     = mfd_pkg::ST_OK;
      if (stv_ff) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (byte_ff == cfg.preamble_byte) begin
                  pre_in = 1'b1;
               end else if (byte_ff == cfg.header_byte) begin
                  sum_in   = byte_ff;
                  cnt_in   = 8'd0;
                  addr_in  = 48'd0;
                  ctl_in   = 8'd0;
                  len_in   = 8'd0;
                  sok_in   = 1'b0;
                  phase_in = PH_ADDR;
               end else begin
                  pre_in = 1'b0;
               end
            end
            PH_ADDR: begin
               for (int k = 0; k < mfd_pkg::AddrBytes; k++) begin
                  if (cnt_ff == 8'(k)) begin
                     addr_in[8*k +: 8] = addr_ff[8*k +: 8] | byte_ff;
                  end
               end
               sum_in = sum_nx;
               cnt_in = cnt_nx;
               if (cnt_nx >= 8'(mfd_pkg::AddrBytes)) begin
                  phase_in = PH_HDR2;
               end
            end
            PH_HDR2: begin
               if (byte_ff != cfg.header_byte) begin
                  push_in.valid            = 1'b1;
                  push_in.res.frame_status = mfd_pkg::ST_NO_HDR2;
                  phase_in = PH_HUNT;
                  pre_in   = 1'b0;
               end else begin
                  sum_in   = sum_nx;
                  phase_in = PH_CTL;
               end
            end
            PH_CTL: begin
               ctl_in   = byte_ff;
               sum_in   = sum_nx;
               phase_in = PH_LEN;
            end
            PH_LEN: begin
               len_in   = byte_ff;
               sum_in   = sum_nx;
               cnt_in   = 8'd0;
               phase_in = (byte_ff == 8'd0) ? PH_CS : PH_DATA;
            end
            PH_DATA: begin
               push_in.valid          = 1'b1;
               push_in.res.kind       = mfd_pkg::KIND_DATA;
               push_in.res.data_value = byte_ff - cfg.data_offset;
               push_in.res.data_index = cnt_ff;
               sum_in = sum_nx;
               cnt_in = cnt_nx;
               if (cnt_nx >= len_ff) begin
                  phase_in = PH_CS;
               end
            end
            PH_CS: begin
               sok_in   = (byte_ff == sum_ff);
               phase_in = PH_END;
            end
            PH_END: begin
               push_in.valid = 1'b1;
               if (byte_ff != cfg.end_byte) begin
                  push_in.res.frame_status = mfd_pkg::ST_BAD_END;
               end else if (!sok_ff) begin
                  push_in.res.frame_status = mfd_pkg::ST_BAD_SUM;
               end
               phase_in = PH_HUNT;
               pre_in   = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stv_ff   <= 1'b0;
         phase_ff <= PH_HUNT;
         cnt_ff   <= 8'd0;
         sum_ff   <= 8'd0;
         len_ff   <= 8'd0;
         addr_ff  <= 48'd0;
         ctl_ff   <= 8'd0;
         sok_ff   <= 1'b0;
         pre_ff   <= 1'b0;
      end else begin
         stv_ff   <= stv_in;
         phase_ff <= phase_in;
         cnt_ff   <= cnt_in;
         sum_ff   <= sum_in;
         len_ff   <= len_in;
         addr_ff  <= addr_in;
         ctl_ff   <= ctl_in;
         sok_ff   <= sok_in;
         pre_ff   <= pre_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         byte_ff <= rx_byte;
      end
   end

   assign stage_valid = stv_ff;
   assign push        = push_in;

endmodule

// ----- src/mfd_rspq.sv -----
`timescale 1ns / 1ps
module mfd_rspq (
   input  logic                     clock,
   input  logic                     reset,
   input  mfd_pkg::push_type        push,
   input  logic                     pop_ready,
   output logic                     head_valid,
   output mfd_pkg::result_type      head,
   output logic [mfd_pkg::QCw-1:0]  fill
);

   mfd_pkg::result_type mem_ff [mfd_pkg::QDepth];
   logic [mfd_pkg::QAw-1:0] wr_ff, wr_in;
   logic [mfd_pkg::QAw-1:0] rd_ff, rd_in;
   logic [mfd_pkg::QCw-1:0] fill_ff, fill_in;
   logic                    pop;

   assign pop = (fill_ff != '0) && pop_ready;

   always_comb begin
      wr_in   = wr_ff;
      rd_in   = rd_ff;
      fill_in = fill_ff;
      if (push.valid) begin
         wr_in = wr_ff + mfd_pkg::QAw'(1);
      end
      if (pop) begin
         rd_in = rd_ff + mfd_pkg::QAw'(1);
      end
      if (push.valid && !pop) begin
         fill_in = fill_ff + mfd_pkg::QCw'(1);
      end else if (!push.valid && pop) begin
         fill_in = fill_ff - mfd_pkg::QCw'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff   <= '0;
         rd_ff   <= '0;
         fill_ff <= '0;
      end else begin
         wr_ff   <= wr_in;
         rd_ff   <= rd_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ff] <= push.res;
      end
   end

   assign head_valid = (fill_ff != '0);
   assign head       = mem_ff[rd_ff];
   assign fill       = fill_ff;

endmodule
